/* src/drfd_pkg.sv */
// Package for the delta run-length frame decoder.
// Holds the command and result types, parse codes and reset constants.
// No dependencies; every other file of the decoder imports it.
`default_nettype none

package drfd_pkg;

    // Register and width constants.
    localparam int FRAME_SIZE_W        = 16;
    localparam int PTR_W               = 17;
    localparam int QUEUE_DEPTH_DEFAULT = 4;
    localparam logic [FRAME_SIZE_W-1:0] FRAME_SIZE_RESET = 16'd6144;

    // Byte codes of the delta stream.
    localparam logic [7:0] SEEK_CODE   = 8'hF0;
    localparam logic [3:0] RUN_NIBBLE  = 4'hF;

    // Parse phase of the front end.
    typedef enum logic [1:0] {
        PH_CMD,
        PH_SEEK_HI,
        PH_SEEK_LO,
        PH_RUN_VAL
    } phase_t;

    // Kind of a command handed from the front end to the back end.
    typedef enum logic [1:0] {
        CMD_NOP,
        CMD_SEEK,
        CMD_LITERAL,
        CMD_RUN
    } cmd_kind_t;

    // One classified input byte.
    typedef struct packed {
        cmd_kind_t   kind;
        logic        frame_start;
        logic [7:0]  data;
        logic [15:0] seek_addr;
        logic [3:0]  count;
    } cmd_t;

    // Back end state.
    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

    // One result word.
    typedef struct packed {
        logic        write_enable;
        logic [15:0] write_addr;
        logic [7:0]  write_data;
        logic        out_of_bounds;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

/* src/drfd_front.sv */
// Front end of the delta run-length frame decoder: parses input bytes into commands.
// Tracks the parse phase, seek high byte and pending run count. Uses drfd_pkg.
`default_nettype none

module drfd_front
    import drfd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] in_byte,
    input  wire logic       frame_start,
    output cmd_t            cmd
);

    phase_t     phase_reg, phase_next;
    logic [7:0] seek_hi_reg, seek_hi_next;
    logic [3:0] run_len_reg, run_len_next;
    phase_t     phase_cur;

    // Phase and parse registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_CMD;
            seek_hi_reg <= '0;
            run_len_reg <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            seek_hi_reg <= seek_hi_next;
            run_len_reg <= run_len_next;
        end
    end

    // Classify the byte and advance the phase. A frame start restarts parsing.
    // While the back end is stopped the phase here may drift, but only a frame
    // start releases the stop, and it returns the phase to command first.
    always_comb
    begin
        phase_cur       = frame_start ? PH_CMD : phase_reg;
        phase_next      = phase_reg;
        seek_hi_next    = seek_hi_reg;
        run_len_next    = run_len_reg;
        cmd.kind        = CMD_NOP;
        cmd.frame_start = frame_start;
        cmd.data        = in_byte;
        cmd.seek_addr   = {seek_hi_reg, in_byte};
        cmd.count       = run_len_reg;

        unique case (phase_cur)
            PH_CMD:
            begin
                if (in_byte == SEEK_CODE)
                begin
                    phase_next = PH_SEEK_HI;
                end
                else if (in_byte[7:4] == RUN_NIBBLE)
                begin
                    run_len_next = in_byte[3:0];
                    phase_next   = PH_RUN_VAL;
                end
                else
                begin
                    cmd.kind   = CMD_LITERAL;
                    phase_next = PH_CMD;
                end
            end
            PH_SEEK_HI:
            begin
                seek_hi_next = in_byte;
                phase_next   = PH_SEEK_LO;
            end
            PH_SEEK_LO:
            begin
                cmd.kind   = CMD_SEEK;
                phase_next = PH_CMD;
            end
            PH_RUN_VAL:
            begin
                cmd.kind     = CMD_RUN;
                run_len_next = '0;
                phase_next   = PH_CMD;
            end
            default:
            begin
                phase_next = PH_CMD;
            end
        endcase

        // Hold all parse state when no byte is taken.
        if (!accept)
        begin
            phase_next   = phase_reg;
            seek_hi_next = seek_hi_reg;
            run_len_next = run_len_reg;
        end
    end

endmodule

`default_nettype wire

/* src/drfd_queue.sv */
// Command queue between the front and back ends of the frame decoder.
// Small first-word-fall-through FIFO of cmd_t words. Uses drfd_pkg.
`default_nettype none

module drfd_queue
    import drfd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT  // power of two, at least 2
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output cmd_t      head,
    output logic      not_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    cmd_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full      = (count_reg == FULL_COUNT);
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

/* src/drfd_back.sv */
// Back end of the frame decoder: executes commands against the write pointer.
// Owns the pointer, the stop flag, run expansion and the output register. Uses drfd_pkg.
`default_nettype none

module drfd_back
    import drfd_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [FRAME_SIZE_W-1:0] frame_size,
    input  wire cmd_t                    head,
    input  wire logic                    head_valid,
    output logic                         pop,
    output result_t                      result,
    output logic                         result_valid,
    input  wire logic                    result_ready
);

    back_state_t      state_reg, state_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic             stopped_reg, stopped_next;
    logic [3:0]       remain_reg, remain_next;
    logic [7:0]       run_data_reg, run_data_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg, out_next;

    logic             can_load;
    logic [PTR_W-1:0] ptr_base;
    logic             stopped_base;
    logic             attempt;
    logic [7:0]       wdata;
    logic             final_write;
    logic [3:0]       remain_after;
    logic             oob;

    assign can_load     = !out_valid_reg || result_ready;
    assign result       = out_reg;
    assign result_valid = out_valid_reg;

    // Command execution and write attempt.
    always_comb
    begin
        state_next     = state_reg;
        ptr_base       = ptr_reg;
        stopped_base   = stopped_reg;
        remain_next    = remain_reg;
        run_data_next  = run_data_reg;
        pop            = 1'b0;
        attempt        = 1'b0;
        wdata          = run_data_reg;
        final_write    = 1'b1;
        remain_after   = remain_reg - 1'b1;
        ptr_next       = ptr_reg;
        stopped_next   = stopped_reg;
        out_next       = out_reg;
        out_valid_next = can_load ? 1'b0 : out_valid_reg;
        oob            = 1'b0;

        unique case (state_reg)
            BK_RUN:
            begin
                attempt     = can_load;
                wdata       = run_data_reg;
                final_write = (remain_reg == 4'd1);
            end
            BK_IDLE:
            begin
                if (head_valid && can_load)
                begin
                    pop = 1'b1;
                    if (head.frame_start)
                    begin
                        ptr_base     = '0;
                        stopped_base = 1'b0;
                    end
                    ptr_next     = ptr_base;
                    stopped_next = stopped_base;
                    if (!stopped_base)
                    begin
                        case (head.kind)
                            CMD_SEEK:
                            begin
                                ptr_next = {1'b0, head.seek_addr};
                            end
                            CMD_LITERAL:
                            begin
                                attempt     = 1'b1;
                                wdata       = head.data;
                                final_write = 1'b1;
                            end
                            CMD_RUN:
                            begin
                                attempt       = (head.count != '0);
                                wdata         = head.data;
                                final_write   = (head.count == 4'd1);
                                remain_after  = head.count - 1'b1;
                                run_data_next = head.data;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        // One write attempt goes to the output register.
        if (attempt)
        begin
            oob                    = (ptr_base >= {1'b0, frame_size});
            out_valid_next         = 1'b1;
            out_next.write_enable  = !oob;
            out_next.write_addr    = ptr_base[15:0];
            out_next.write_data    = wdata;
            out_next.out_of_bounds = oob;
            out_next.last          = oob || final_write;
            if (oob)
            begin
                stopped_next = 1'b1;
                state_next   = BK_IDLE;
            end
            else
            begin
                ptr_next    = ptr_base + 1'b1;
                remain_next = remain_after;
                state_next  = final_write ? BK_IDLE : BK_RUN;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            ptr_reg       <= '0;
            stopped_reg   <= 1'b0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            stopped_reg   <= stopped_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        run_data_reg <= run_data_next;
        out_reg      <= out_next;
    end

endmodule

`default_nettype wire

/* src/delta_rle_frame_decoder.sv */
// Delta run-length frame decoder: turns a delta byte stream into frame memory writes.
// A byte's command is registered in the queue and its results in the output register.
// One byte per cycle is taken for literals and commands while the queue has room; a run
// of n writes holds the back end, one word per cycle with m_tready high; the queue fills.
// Reset clears the parse phase, pointer, stop flag and queue; frame_size returns to 6144.
// Uses drfd_pkg, drfd_front, drfd_queue and drfd_back.
`default_nettype none

module delta_rle_frame_decoder
    import drfd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // Configuration write channel: frame_size.
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [FRAME_SIZE_W-1:0] cfg_data,
    // Slave side.
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [7:0]              s_tdata,   // [7:0] in_byte
    input  wire logic                    s_tuser,   // [0] frame_start
    // Master side.
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [23:0]                  m_tdata,   // [15:0] write_addr, [23:16] write_data
    output logic [1:0]                   m_tuser,   // [0] write_enable, [1] out_of_bounds
    output logic                         m_tlast    // last
);

    logic [FRAME_SIZE_W-1:0] frame_size_reg;
    logic                    in_accept;
    logic                    q_full;
    logic                    q_not_empty;
    logic                    q_pop;
    cmd_t                    front_cmd;
    cmd_t                    q_head;
    result_t                 result;

    // Configuration register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_size_reg <= FRAME_SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            frame_size_reg <= cfg_data;
        end
    end

    // Input handshake: a byte is taken whenever the queue has room.
    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    drfd_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_accept),
        .in_byte     (s_tdata),
        .frame_start (s_tuser),
        .cmd         (front_cmd)
    );

    drfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept),
        .push_cmd  (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .not_empty (q_not_empty)
    );

    drfd_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_size   (frame_size_reg),
        .head         (q_head),
        .head_valid   (q_not_empty),
        .pop          (q_pop),
        .result       (result),
        .result_valid (m_tvalid),
        .result_ready (m_tready)
    );

    // Output word packing.
    assign m_tdata = {result.write_data, result.write_addr};
    assign m_tuser = {result.out_of_bounds, result.write_enable};
    assign m_tlast = result.last;

    // A result word is either a write or a refusal, never both.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("write and out-of-bounds flagged together");

    // A refused write ends the results of its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> m_tlast)
        else $error("out-of-bounds word not marked last");

    // Every granted write lies inside the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[15:0] < frame_size_reg))
        else $error("write address at or beyond frame size");

endmodule

`default_nettype wire

/* test/delta_rle_frame_decoder_tb.sv */
// Testbench for delta_rle_frame_decoder: drives encoded delta bytes and checks every write word.
// A local decoder model predicts each write word; depends on drfd_pkg and the decoder RTL only.
`timescale 1ns / 100ps

module delta_rle_frame_decoder_tb
    import drfd_pkg::*;
;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 16;

    // Clock, reset and block inputs, all known from time zero.
    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [FRAME_SIZE_W-1:0] cfg_data = '0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [7:0]              s_tdata = '0;    // [7:0] in_byte
    logic                    s_tuser = 1'b0;  // [0] frame_start
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [23:0]             m_tdata;         // [15:0] write_addr, [23:16] write_data
    logic [1:0]              m_tuser;         // [0] write_enable, [1] out_of_bounds
    logic                    m_tlast;

    // Decoder model state and its copy of frame_size.
    logic [FRAME_SIZE_W-1:0] frame_size_cfg = FRAME_SIZE_RESET;
    phase_t                  parse_state = PH_CMD;
    logic [7:0]              seek_hi = '0;
    logic [3:0]              run_left = '0;
    logic [PTR_W-1:0]        wptr = '0;
    logic                    stopped = 1'b0;

    // Write words predicted and not yet seen on the master side.
    result_t writes_due[$];
    result_t want;

    int mismatches = 0;
    int cycles = 0;
    int live_bytes = 0;
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    delta_rle_frame_decoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    // Cycle counter with a hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL delta_rle_frame_decoder");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus long hold-offs on request.
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = 300;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        mismatches++;
        if (mismatches <= 50)
            $display("ERROR at %0t: %s got 0x%0h, wanted 0x%0h", $time, what, got, exp_val);
    endtask

    // Checks each accepted write word against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (writes_due.size() == 0)
            begin
                report_mismatch("unexpected word, addr", 32'(m_tdata[15:0]), 32'd0);
            end
            else
            begin
                want = writes_due.pop_front();
                if (m_tuser[0] !== want.write_enable)
                    report_mismatch("write_enable", 32'(m_tuser[0]),
                                    32'(want.write_enable));
                if (m_tdata[15:0] !== want.write_addr)
                    report_mismatch("write_addr", 32'(m_tdata[15:0]),
                                    32'(want.write_addr));
                if (m_tdata[23:16] !== want.write_data)
                    report_mismatch("write_data", 32'(m_tdata[23:16]),
                                    32'(want.write_data));
                if (m_tuser[1] !== want.out_of_bounds)
                    report_mismatch("out_of_bounds", 32'(m_tuser[1]),
                                    32'(want.out_of_bounds));
                if (m_tlast !== want.last)
                    report_mismatch("last", 32'(m_tlast), 32'(want.last));
            end
        end
    end

    // Tries one write at the pointer; a refused write stops decoding.
    function automatic bit try_frame_write(input logic [7:0] data, input logic last_if_ok);
        result_t w;
        w.write_addr = wptr[15:0];
        w.write_data = data;
        if (wptr >= {1'b0, frame_size_cfg})
        begin
            w.write_enable  = 1'b0;
            w.out_of_bounds = 1'b1;
            w.last          = 1'b1;
            stopped         = 1'b1;
            writes_due.push_back(w);
            return 1'b0;
        end
        w.write_enable  = 1'b1;
        w.out_of_bounds = 1'b0;
        w.last          = last_if_ok;
        wptr            = wptr + 1'b1;
        writes_due.push_back(w);
        return 1'b1;
    endfunction

    // Decodes one accepted byte and queues the write words it causes.
    task automatic decode_byte(input logic [7:0] b, input logic fs);
        int i;
        if (fs)
        begin
            wptr        = '0;
            parse_state = PH_CMD;
            stopped     = 1'b0;
        end
        if (!stopped)
        begin
            live_bytes++;
            case (parse_state)
                PH_CMD:
                begin
                    if (b == SEEK_CODE)
                        parse_state = PH_SEEK_HI;
                    else if (b[7:4] == RUN_NIBBLE)
                    begin
                        run_left    = b[3:0];
                        parse_state = PH_RUN_VAL;
                    end
                    else
                        void'(try_frame_write(b, 1'b1));
                end
                PH_SEEK_HI:
                begin
                    seek_hi     = b;
                    parse_state = PH_SEEK_LO;
                end
                PH_SEEK_LO:
                begin
                    wptr        = {1'b0, seek_hi, b};
                    parse_state = PH_CMD;
                end
                default:
                begin
                    for (i = 0; i < int'(run_left); i++)
                    begin
                        if (!try_frame_write(b, i == int'(run_left) - 1))
                            break;
                    end
                    run_left    = '0;
                    parse_state = PH_CMD;
                end
            endcase
        end
    endtask

    // Idles a random number of cycles, then offers one word on the slave side
    // and waits for it to be taken.
    task automatic send_byte(input logic [7:0] b, input logic fs);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= fs;
        do @(posedge clk); while (!s_tready);
        decode_byte(b, fs);
    endtask

    // Waits until every predicted word has come out.
    task automatic wait_drained();
        while (writes_due.size() != 0)
            @(posedge clk);
    endtask

    // Writes frame_size once the block has gone idle.
    task automatic set_frame_size(input logic [FRAME_SIZE_W-1:0] value);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid      <= 1'b0;
        frame_size_cfg  = value;
    endtask

    task automatic set_idling(input int snd_pct, input int rcv_pct);
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
    endtask

    // Literals with both values on every data bit.
    task automatic test_literals();
        send_byte(8'h00, 1'b1);
        send_byte(8'hEF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
    endtask

    // Shortest run, longest run and one in between.
    task automatic test_runs();
        send_byte(8'hF1, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hF7, 1'b0);
        send_byte(8'h5A, 1'b0);
    endtask

    // Seeks, a run that crosses the frame end, the stopped state, a seek past the
    // frame, and a command cut short by a new frame.
    task automatic test_seek_and_bounds();
        send_byte(SEEK_CODE, 1'b0);
        send_byte(8'h17, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'hF4, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(SEEK_CODE, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(SEEK_CODE, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h12, 1'b1);
    endtask

    // Well-formed frames with random content, mixed with cut commands and noise.
    task automatic random_frames(input int n_items);
        int start_count;
        int pick;
        int target;
        logic fs_next;
        start_count = live_bytes;
        fs_next = 1'b1;
        while (live_bytes - start_count < n_items)
        begin
            if (stopped && $urandom_range(0, 2) != 0)
                fs_next = 1'b1;
            if ($urandom_range(0, 24) == 0)
                fs_next = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                send_byte(8'($urandom_range(0, 8'hEF)), fs_next);
            end
            else if (pick < 75)
            begin
                send_byte(8'($urandom_range(8'hF1, 8'hFF)), fs_next);
                send_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            else if (pick < 90)
            begin
                // Seek targets cluster around the frame end so runs cross it.
                if ($urandom_range(0, 9) == 0)
                    target = $urandom_range(0, 65535);
                else if ($urandom_range(0, 2) == 0)
                    target = int'(frame_size_cfg) - int'($urandom_range(0, 20));
                else
                    target = $urandom_range(0, int'(frame_size_cfg) + 20);
                if (target < 0)
                    target = 0;
                if (target > 65535)
                    target = 65535;
                send_byte(SEEK_CODE, fs_next);
                send_byte(target[15:8], 1'b0);
                send_byte(target[7:0], 1'b0);
            end
            else if (pick < 95)
            begin
                // A command head left without its operands.
                send_byte(8'($urandom_range(8'hF0, 8'hFF)), fs_next);
            end
            else
            begin
                send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            fs_next = 1'b0;
        end
    endtask

    // Holds the receiver off while long runs keep coming, then lets it drain.
    task automatic test_backpressure();
        int i;
        hold_req++;
        send_byte(8'h01, 1'b1);
        for (i = 0; i < 8; i++)
        begin
            send_byte(8'hFF, 1'b0);
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        s_tvalid <= 1'b0;
        wait_drained();
        send_byte(8'hF9, 1'b0);
        send_byte(8'h3C, 1'b0);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(27, 58);
        test_literals();
        test_runs();
        test_seek_and_bounds();

        set_frame_size(16'hFFFF);
        random_frames(28);
        set_frame_size(16'd1);
        random_frames(10);

        set_idling(58, 27);
        set_frame_size(16'd0);
        random_frames(6);
        set_frame_size(16'($urandom_range(20, 200)));
        random_frames(32);

        set_idling(0, 0);
        set_frame_size(FRAME_SIZE_RESET);
        test_backpressure();
        random_frames(40);

        // Let the last words out before the verdict.
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS delta_rle_frame_decoder");
        else
            $display("FAIL delta_rle_frame_decoder");
        $finish;
    end

endmodule
